// ----- sv/mspc_pkg.sv -----
// Shared types, constants and register codes of the motor speed PI controller.
package mspc_pkg;

    localparam int ADC_BITS       = 12;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [1:0] OP_EDGE_A  = 2'd0;
    localparam logic [1:0] OP_EDGE_B  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_CONTROL = 2'd3;

    localparam logic [1:0] MODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_TUNE   = 2'd2;

    localparam logic [3:0] KEY_CLEAR  = 4'd0;
    localparam logic [3:0] KEY_CW     = 4'd1;
    localparam logic [3:0] KEY_P_UP   = 4'd2;
    localparam logic [3:0] KEY_I_UP   = 4'd3;
    localparam logic [3:0] KEY_CCW    = 4'd4;
    localparam logic [3:0] KEY_P_DN   = 4'd5;
    localparam logic [3:0] KEY_I_DN   = 4'd6;
    localparam logic [3:0] KEY_OPEN   = 4'd7;
    localparam logic [3:0] KEY_CLOSED = 4'd8;
    localparam logic [3:0] KEY_TUNE   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_PLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_TO_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN_STEP = 3'd5;

    localparam logic [11:0] RST_MAX_SPEED   = 12'd360;
    localparam logic [15:0] RST_PWM_PERIOD  = 16'd240;
    localparam logic [15:0] RST_RPM_PER_PLS = 16'd1369;
    localparam logic [15:0] RST_RPM_TO_DUTY = 16'd43691;
    localparam logic [23:0] RST_P_GAIN_STEP = 24'd1677722;
    localparam logic [23:0] RST_I_GAIN_STEP = 24'd16777;
    localparam logic [7:0]  RST_MULT        = 8'd5;

    localparam logic [31:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_C = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ADC_BITS-1:0] pot_sample;
        logic [3:0]          touch_key;
    } req_t;

    typedef struct packed {
        logic [15:0] duty;
        logic        duty_updated;
        logic        drive_a;
        logic        drive_b;
        logic [15:0] measured_rpm;
        logic [11:0] desired_rpm;
        logic [1:0]  mode_now;
        logic [7:0]  p_mult_now;
        logic [7:0]  i_mult_now;
    } res_t;

    typedef struct packed {
        logic [11:0] max_speed_rpm;
        logic [15:0] pwm_period;
        logic [15:0] rpm_per_pulse;
        logic [15:0] rpm_to_duty;
        logic [23:0] p_gain_step;
        logic [23:0] i_gain_step;
    } cfg_t;

endpackage

// ----- sv/mspc_mul.sv -----
// Shared unsigned multiplier with registered product.
module mspc_mul #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;
    logic [A_W+B_W-1:0] p_next;

    assign p_next = (A_W + B_W)'(a) * (A_W + B_W)'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- sv/mspc_core.sv -----
// Sequencer, controller state and PI datapath around the shared multiplier.
module mspc_core import mspc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    input  cfg_t cfg,
    input  logic take,
    output logic ready,
    output logic done,
    output res_t res
);

    localparam int WIN_W = COUNT_BITS + 1;
    localparam int MQ_W  = WIN_W + 16;
    localparam int MA_W  = (WIN_W > 32) ? WIN_W : 32;
    localparam int P_W   = MA_W + 16;
    localparam int DW    = (MQ_W + 1 > 33) ? MQ_W + 1 : 33;
    localparam int U_W   = 50;
    localparam int T_W   = 49;

    typedef enum logic [4:0] {
        S_IDLE, S_DESIRED, S_CHECK, S_MEASURE, S_OPEN, S_INTEG, S_GAIN_P, S_GAIN_I,
        S_P_LO, S_P_HI, S_P_SUM, S_I_LO, S_I_HI, S_I_SUM, S_DUTY, S_KEY, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [WIN_W-1:0]      window_reg, window_next;
    logic                  win_rdy_reg, win_rdy_next;
    logic                  dir_reg, dir_next;
    logic [1:0]            mode_reg, mode_next;
    logic [7:0]            pm_reg, pm_next, im_reg, im_next;
    logic [31:0]           integ_reg, integ_next;
    logic [15:0]           last_duty_reg, last_duty_next;
    logic [15:0]           shown_reg, shown_next;
    logic [ADC_BITS-1:0]   pot_reg, pot_next;
    logic [3:0]            key_reg, key_next;
    logic [11:0]           desired_reg, desired_next;
    logic [19:0]           dq_reg, dq_next;
    logic [31:0]           err_reg, err_next;
    logic [31:0]           kp_reg, kp_next, ki_reg, ki_next;
    logic [31:0]           mag_reg, mag_next, acc_reg, acc_next;
    logic [U_W-1:0]        u_reg, u_next;
    logic                  upd_reg, upd_next;

    logic [MA_W-1:0]       op_a;
    logic [15:0]           op_b;
    logic [P_W-1:0]        p;

    logic [MQ_W-1:0]       mq;
    logic [DW-1:0]         diff;
    logic [32:0]           isum;
    logic [15:0]           open_duty;
    logic [31:0]           err_mag, integ_mag;
    logic [T_W-1:0]        term;
    logic [U_W-1:0]        rnd;
    logic [U_W-17:0]       rduty;
    logic                  tuning;

    mspc_mul #(
        .A_W (MA_W),
        .B_W (16)
    ) u_mul (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .p   (p)
    );

    assign mq        = p[MQ_W-1:0];
    assign diff      = DW'(dq_reg) - DW'(mq);
    assign isum      = {integ_reg[31], integ_reg} + {err_reg[31], err_reg};
    assign open_duty = p[ADC_BITS+15:ADC_BITS];
    assign err_mag   = err_reg[31] ? 32'(-err_reg) : err_reg;
    assign integ_mag = integ_reg[31] ? 32'(-integ_reg) : integ_reg;
    assign term      = T_W'(acc_reg) + T_W'(p[47:0]);
    assign rnd       = u_reg + U_W'(32768);
    assign rduty     = rnd[U_W-1:16];
    assign tuning    = (mode_reg == MODE_TUNE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        window_next    = window_reg;
        win_rdy_next   = win_rdy_reg;
        dir_next       = dir_reg;
        mode_next      = mode_reg;
        pm_next        = pm_reg;
        im_next        = im_reg;
        integ_next     = integ_reg;
        last_duty_next = last_duty_reg;
        shown_next     = shown_reg;
        pot_next       = pot_reg;
        key_next       = key_reg;
        desired_next   = desired_reg;
        dq_next        = dq_reg;
        err_next       = err_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        u_next         = u_reg;
        upd_next       = upd_reg;
        op_a           = '0;
        op_b           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pot_next     = req.pot_sample;
                    key_next     = req.touch_key;
                    desired_next = '0;
                    upd_next     = 1'b0;
                    state_next   = S_DONE;
                    unique case (req.opcode)
                        OP_EDGE_A: cnt_a_next = cnt_a_reg + 1'b1;
                        OP_EDGE_B: cnt_b_next = cnt_b_reg + 1'b1;
                        OP_TICK:
                        begin
                            window_next  = WIN_W'(cnt_a_reg) + WIN_W'(cnt_b_reg);
                            cnt_a_next   = '0;
                            cnt_b_next   = '0;
                            win_rdy_next = 1'b1;
                        end
                        OP_CONTROL: state_next = S_DESIRED;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DESIRED:
            begin
                op_a       = MA_W'(pot_reg);
                op_b       = 16'(cfg.max_speed_rpm);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                desired_next = p[ADC_BITS+11:ADC_BITS];
                dq_next      = p[ADC_BITS+11:ADC_BITS-8];
                op_a         = MA_W'(window_reg);
                op_b         = cfg.rpm_per_pulse;
                state_next   = win_rdy_reg ? S_MEASURE : S_KEY;
            end
            S_MEASURE:
            begin
                if (|mq[MQ_W-1:24])
                    shown_next = 16'hFFFF;
                else
                    shown_next = mq[23:8];
                if (diff[DW-1:31] == '0 || diff[DW-1:31] == '1)
                    err_next = diff[31:0];
                else
                    err_next = diff[DW-1] ? INT32_MIN_C : INT32_MAX_C;
                op_a       = MA_W'(pot_reg);
                op_b       = cfg.pwm_period;
                state_next = (mode_reg == MODE_OPEN) ? S_OPEN : S_INTEG;
            end
            S_OPEN:
            begin
                last_duty_next = (open_duty > cfg.pwm_period) ? cfg.pwm_period : open_duty;
                upd_next       = 1'b1;
                window_next    = '0;
                win_rdy_next   = 1'b0;
                state_next     = S_KEY;
            end
            S_INTEG:
            begin
                if (isum[32] != isum[31])
                    integ_next = isum[32] ? INT32_MIN_C : INT32_MAX_C;
                else
                    integ_next = isum[31:0];
                op_a       = MA_W'(cfg.p_gain_step);
                op_b       = 16'(pm_reg);
                state_next = S_GAIN_P;
            end
            S_GAIN_P:
            begin
                kp_next    = p[31:0];
                op_a       = MA_W'(cfg.i_gain_step);
                op_b       = 16'(im_reg);
                state_next = S_GAIN_I;
            end
            S_GAIN_I:
            begin
                ki_next    = p[31:0];
                op_a       = MA_W'(err_mag);
                op_b       = cfg.rpm_to_duty;
                state_next = S_P_LO;
            end
            S_P_LO:
            begin
                mag_next   = p[47:16];
                op_a       = MA_W'(p[47:16]);
                op_b       = kp_reg[15:0];
                state_next = S_P_HI;
            end
            S_P_HI:
            begin
                acc_next   = p[47:16];
                op_a       = MA_W'(mag_reg);
                op_b       = kp_reg[31:16];
                state_next = S_P_SUM;
            end
            S_P_SUM:
            begin
                u_next     = err_reg[31] ? U_W'(-U_W'(term)) : U_W'(term);
                op_a       = MA_W'(integ_mag);
                op_b       = cfg.rpm_to_duty;
                state_next = S_I_LO;
            end
            S_I_LO:
            begin
                mag_next   = p[47:16];
                op_a       = MA_W'(p[47:16]);
                op_b       = ki_reg[15:0];
                state_next = S_I_HI;
            end
            S_I_HI:
            begin
                acc_next   = p[47:16];
                op_a       = MA_W'(mag_reg);
                op_b       = ki_reg[31:16];
                state_next = S_I_SUM;
            end
            S_I_SUM:
            begin
                u_next     = integ_reg[31] ? u_reg - U_W'(term) : u_reg + U_W'(term);
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                if (u_reg[U_W-1] || u_reg == '0)
                    last_duty_next = '0;
                else if (rduty > (U_W-16)'(cfg.pwm_period))
                    last_duty_next = cfg.pwm_period;
                else
                    last_duty_next = rduty[15:0];
                upd_next     = 1'b1;
                window_next  = '0;
                win_rdy_next = 1'b0;
                state_next   = S_KEY;
            end
            S_KEY:
            begin
                unique case (key_reg)
                    KEY_CW:     dir_next  = 1'b0;
                    KEY_CCW:    dir_next  = 1'b1;
                    KEY_OPEN:   mode_next = MODE_OPEN;
                    KEY_CLOSED: mode_next = MODE_CLOSED;
                    KEY_TUNE:   mode_next = MODE_TUNE;
                    KEY_P_UP:   if (tuning && pm_reg != 8'hFF) pm_next = pm_reg + 1'b1;
                    KEY_P_DN:   if (tuning && pm_reg != 8'h00) pm_next = pm_reg - 1'b1;
                    KEY_I_UP:   if (tuning && im_reg != 8'hFF) im_next = im_reg + 1'b1;
                    KEY_I_DN:   if (tuning && im_reg != 8'h00) im_next = im_reg - 1'b1;
                    KEY_CLEAR:
                    begin
                        if (tuning)
                        begin
                            pm_next = '0;
                            im_next = '0;
                        end
                    end
                    default: ;
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            window_reg    <= '0;
            win_rdy_reg   <= 1'b0;
            dir_reg       <= 1'b1;
            mode_reg      <= MODE_OPEN;
            pm_reg        <= RST_MULT;
            im_reg        <= RST_MULT;
            integ_reg     <= '0;
            last_duty_reg <= '0;
            shown_reg     <= '0;
            pot_reg       <= '0;
            key_reg       <= '0;
            desired_reg   <= '0;
            dq_reg        <= '0;
            err_reg       <= '0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            mag_reg       <= '0;
            acc_reg       <= '0;
            u_reg         <= '0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            window_reg    <= window_next;
            win_rdy_reg   <= win_rdy_next;
            dir_reg       <= dir_next;
            mode_reg      <= mode_next;
            pm_reg        <= pm_next;
            im_reg        <= im_next;
            integ_reg     <= integ_next;
            last_duty_reg <= last_duty_next;
            shown_reg     <= shown_next;
            pot_reg       <= pot_next;
            key_reg       <= key_next;
            desired_reg   <= desired_next;
            dq_reg        <= dq_next;
            err_reg       <= err_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            mag_reg       <= mag_next;
            acc_reg       <= acc_next;
            u_reg         <= u_next;
            upd_reg       <= upd_next;
        end
    end

    assign ready = (state_reg == S_IDLE);
    assign done  = (state_reg == S_DONE);

    always_comb
    begin
        res.duty         = last_duty_reg;
        res.duty_updated = upd_reg;
        res.drive_a      = dir_reg;
        res.drive_b      = ~dir_reg;
        res.measured_rpm = shown_reg;
        res.desired_rpm  = desired_reg;
        res.mode_now     = mode_reg;
        res.p_mult_now   = pm_reg;
        res.i_mult_now   = im_reg;
    end

endmodule

// ----- sv/motor_speed_pi_controller_top.sv -----
// Top level of the motor speed PI controller: configuration, request and result ports.
//
// One request at a time. An encoder edge or an update tick goes from idle straight to done.
// A control step forms the desired speed; when no window is ready it goes on to the key
// handling, else it measures the speed and sets the open-loop duty or runs the PI steps of
// the closed-loop modes before the key handling. The result reaches the result register at
// the edge at which the sequencer returns to idle; until the register can take it, the
// sequencer waits in done. The steps are set by the single 32x16 multiplier, with a
// registered product, that every product of the control law passes through in turn; the
// wider gain products take two passes, low and high halves. The next request is accepted
// as soon as the sequencer is idle, even while the last result still waits to be taken.
module motor_speed_pi_controller_top import mspc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  req_t                  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    logic core_ready, core_done, take, start;
    res_t core_res;

    assign start = item_valid && core_ready;
    assign take  = !res_valid_reg || result_ready;

    mspc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (item),
        .cfg   (cfg_reg),
        .take  (take),
        .ready (core_ready),
        .done  (core_done),
        .res   (core_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_SPEED:   cfg_next.max_speed_rpm = cfg_data[11:0];
                REG_PWM_PERIOD:  cfg_next.pwm_period    = cfg_data[15:0];
                REG_RPM_PER_PLS: cfg_next.rpm_per_pulse = cfg_data[15:0];
                REG_RPM_TO_DUTY: cfg_next.rpm_to_duty   = cfg_data[15:0];
                REG_P_GAIN_STEP: cfg_next.p_gain_step   = cfg_data;
                REG_I_GAIN_STEP: cfg_next.i_gain_step   = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (core_done && take)
        begin
            res_valid_next = 1'b1;
            res_next       = core_res;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed_rpm <= RST_MAX_SPEED;
            cfg_reg.pwm_period    <= RST_PWM_PERIOD;
            cfg_reg.rpm_per_pulse <= RST_RPM_PER_PLS;
            cfg_reg.rpm_to_duty   <= RST_RPM_TO_DUTY;
            cfg_reg.p_gain_step   <= RST_P_GAIN_STEP;
            cfg_reg.i_gain_step   <= RST_I_GAIN_STEP;
            res_valid_reg         <= 1'b0;
            res_reg               <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign item_ready   = core_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request accepted but sequencer did not leave idle");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.duty_updated |-> result.duty <= cfg_reg.pwm_period)
        else $error("new duty above pwm period");

    a_drive_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.drive_b == !result.drive_a)
        else $error("driver inputs not complementary");

endmodule
